// File: rtl/lrct_pkg.sv
// ----------------------------------------------------------------------------
// lrct_pkg
// Shared types and constants for the link reference count table.
// ----------------------------------------------------------------------------
package lrct_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int OCC_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 32;
  localparam int USE_W    = 6;

  localparam int IN_BITS  = FUNC_W + 2 * KEY_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + 1 + COUNT_W + USE_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] OP_INCR   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DECR   = 2'd1;
  localparam logic [FUNC_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 32'd1;
  localparam logic [COUNT_W-1:0] COUNT_NEW = 32'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key_hi;
    logic [KEY_W-1:0]  key_lo;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  link_total;
    logic [USE_W-1:0]    entries_in_use;
  } resp_t;

endpackage

// File: rtl/lrct_table.sv
// ----------------------------------------------------------------------------
// lrct_table
// Entry storage with parallel key match, lowest free slot selection and
// single entry update per operation.
// ----------------------------------------------------------------------------
module lrct_table
  import lrct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_en,
  input  req_t  req,
  output resp_t resp
);

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [KEY_W-1:0]         key_high_store [TABLE_ENTRIES];
  logic [KEY_W-1:0]         key_low_store  [TABLE_ENTRIES];
  logic [COUNT_W-1:0]       count_store    [TABLE_ENTRIES];
  logic [OCC_W-1:0]         occupancy;

  logic [TABLE_ENTRIES-1:0] hit;
  logic                     hit_any;
  logic [IDX_W-1:0]         hit_idx;
  logic                     free_any;
  logic [IDX_W-1:0]         free_idx;
  logic [COUNT_W-1:0]       cur_count;

  logic                     wr_en;
  logic                     wr_key;
  logic [IDX_W-1:0]         wr_idx;
  logic [COUNT_W-1:0]       wr_count;
  logic                     set_valid;
  logic                     clr_valid;
  logic [OCC_W-1:0]         occupancy_next;
  logic [COUNT_W-1:0]       res_count;
  logic [STATUS_W-1:0]      res_status;
  logic [31:0]              occ_ext;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i] = entry_valid[i] && (key_high_store[i] == req.key_hi) &&
               (key_low_store[i] == req.key_lo);
    end
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign cur_count = count_store[hit_idx];

  always_comb begin
    wr_en          = 1'b0;
    wr_key         = 1'b0;
    wr_idx         = hit_idx;
    wr_count       = cur_count;
    set_valid      = 1'b0;
    clr_valid      = 1'b0;
    occupancy_next = occupancy;
    res_count      = '0;
    res_status     = ST_OK;
    unique case (req.func)
      OP_INCR: begin
        if (hit_any) begin
          wr_en     = 1'b1;
          wr_count  = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_ONE;
          res_count = wr_count;
        end else if (free_any) begin
          wr_en          = 1'b1;
          wr_key         = 1'b1;
          wr_idx         = free_idx;
          wr_count       = COUNT_NEW;
          set_valid      = 1'b1;
          occupancy_next = occupancy + OCC_W'(1);
          res_count      = COUNT_NEW;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_DECR: begin
        if (hit_any) begin
          wr_en     = 1'b1;
          wr_count  = (cur_count == '0) ? cur_count : cur_count - COUNT_ONE;
          res_count = wr_count;
          if (wr_count < COUNT_NEW) begin
            clr_valid = 1'b1;
            if (occupancy != '0) begin
              occupancy_next = occupancy - OCC_W'(1);
            end
          end
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit_any) begin
          res_count = cur_count;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  assign occ_ext = 32'(occupancy_next);

  always_comb begin
    resp.status         = res_status;
    resp.found          = hit_any;
    resp.link_total     = res_count;
    resp.entries_in_use = occ_ext[USE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
    end else if (req_en) begin
      occupancy <= occupancy_next;
      if (set_valid) begin
        entry_valid[wr_idx] <= 1'b1;
      end
      if (clr_valid) begin
        entry_valid[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_en && wr_en) begin
      count_store[wr_idx] <= wr_count;
      if (wr_key) begin
        key_high_store[wr_idx] <= req.key_hi;
        key_low_store[wr_idx]  <= req.key_lo;
      end
    end
  end

endmodule

// File: rtl/link_reference_count_table_unit.sv
// ----------------------------------------------------------------------------
// link_reference_count_table_unit
// Table of 128-bit object identifiers with link counts: increment, decrement
// and lookup, one result per operation.
//
//   Port group   Dir  Payload (low bit first)
//   s_*          in   func[1:0], key_hi[63:0], key_lo[63:0]
//   m_*          out  status[1:0], found, link_total[31:0], entries_in_use[5:0]
//
// One operation per cycle sustained while m_tready holds; a result is offered
// on m_* once its input transfer has passed the input register and then the
// table update into the result register.
// Reset clears the valid marks and occupancy; no clearing pass.
// A stalled result holds the pipe; the input register still takes one item.
// ----------------------------------------------------------------------------
module link_reference_count_table_unit
  import lrct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // func, key_hi, key_lo, zero fill
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status, found, link_total, entries_in_use, zero fill
);

  logic  in_valid;
  req_t  in_req;
  logic  out_valid;
  resp_t out_resp;
  resp_t resp;
  logic  advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  lrct_table u_table (
    .clk    (clk),
    .rst    (rst),
    .req_en (advance),
    .req    (in_req),
    .resp   (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.func   <= s_tdata[FUNC_W-1:0];
      in_req.key_hi <= s_tdata[FUNC_W +: KEY_W];
      in_req.key_lo <= s_tdata[FUNC_W + KEY_W +: KEY_W];
    end
    if (advance) begin
      out_resp <= resp;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_resp.entries_in_use, out_resp.link_total,
                            out_resp.found, out_resp.status});

endmodule
